// ----- hw/rtl/bb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb_pkg: shared types and constants of the 3x3 box blur
// Channel layout, register indexes, command codes, window control bundle and
// the reciprocal table used for the rounded average.
// ----------------------------------------------------------------------------
package bb_pkg;

	// pixel layout: red [7:0], green [15:8], blue [23:16]
	localparam int CH_N   = 3;
	localparam int CHAN_W = 8;
	localparam int PIX_W  = CH_N * CHAN_W;
	localparam int SLOTS  = 3;

	// column sum of three pixels, window sum of nine, 2*sum + n
	localparam int COL_W = 10;
	localparam int SUM_W = 12;
	localparam int NUM_W = 13;
	localparam int CNT_W = 4;

	// average = (2*sum + n) * ceil(2^18 / 2n) >> 18, exact for NUM_W numerators
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// configuration registers
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

	// input beat kinds
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// window control from the sequencer
	typedef struct packed {
		logic shift;      // shift a new column into the newest slot
		logic col_valid;  // the new column lies inside the frame
		logic hist_clear; // older slots are left of the frame
		logic a_en;       // include the older line store row
		logic c_en;       // include the incoming pixel row
		logic sum_load;   // register the window sum
	} win_ctrl_t;

	// reciprocal of 2n for the neighbor counts that can occur
	function automatic logic [RECIP_W-1:0] bb_recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd6:    r = 18'd21846;
			4'd9:    r = 18'd14564;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/box_blur_3x3_edge_aware.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: streaming 3x3 box blur over an RGB raster frame
// Push beats carry pixels in raster order; drain beats release the last row.
// ----------------------------------------------------------------------------
// Each output pixel is the per-channel average of its in-frame 3x3
// neighborhood, rounded half up. Output runs one row and one pixel behind
// input; once the frame is in, one drain beat (s_tuser = 1) releases each
// pixel of the final row and m_tlast marks the frame's last pixel. Pushes
// after the frame is in and drains before it is in are dropped. Writing
// either register restarts the frame. Beats are handled one at a time by a
// sequencer around a single line store RAM (one read and one write port,
// older and newer row per word), so a new beat is taken only once the last
// one and its results are through; a stalled output holds the sequencer.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware
	import bb_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [PIX_W-1:0]      s_tdata,  // in_red, in_green, in_blue
	input  wire logic                  s_tuser,  // command
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [PIX_W-1:0]      m_tdata,  // out_red, out_green, out_blue
	output logic                       m_tlast   // frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_D0,
		S_DSH,
		S_INV,
		S_SUM,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [WIDTH_W-1:0]     width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [CW-1:0]          in_col_q;
	logic [HEIGHT_W-1:0]    in_row_q;
	logic [CW-1:0]          out_col_q;
	logic [CW-1:0]          x_q;
	logic [PIX_W-1:0]       px_q;
	logic                   top_q;
	logic                   emit1_q;
	logic                   second_q;
	logic                   last_q;

	logic [CW-1:0]          last_col;
	logic [HEIGHT_W-1:0]    last_row;
	logic                   frame_in;
	logic                   accept;
	logic                   push_ok;
	logic                   drain_ok;

	logic                   mem_re;
	logic [CW-1:0]          mem_raddr;
	logic                   mem_we;
	logic [2*PIX_W-1:0]     mem_rdata;
	logic [2*PIX_W-1:0]     mem_wdata;

	win_ctrl_t              win_ctrl;
	logic [CH_N-1:0][NUM_W-1:0] numer;
	logic [RECIP_W-1:0]     recip;
	logic                   rnd_load;
	logic                   rnd_free;

	// effective frame size
	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(width_q - 12'd1);
		end
		last_row = (height_q == '0) ? '0 : height_q - 16'd1;
		frame_in = in_row_q > last_row;
	end

	// input handshake
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign push_ok  = accept && (s_tuser == CMD_PUSH) && !frame_in
		&& (in_col_q <= last_col);
	assign drain_ok = accept && (s_tuser == CMD_DRAIN) && frame_in
		&& (out_col_q <= last_col);

	// line store read requests
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (push_ok) begin
			mem_re    = 1'b1;
			mem_raddr = in_col_q;
		end else if (drain_ok) begin
			if (out_col_q == '0) begin
				mem_re = 1'b1;
			end else if (out_col_q < last_col) begin
				mem_re    = 1'b1;
				mem_raddr = out_col_q + CW'(1);
			end
		end else if (state_q == S_D0 && last_col != '0) begin
			mem_re    = 1'b1;
			mem_raddr = CW'(1);
		end
	end

	// line store write back: newer row moves to older, pixel becomes newer
	assign mem_we    = (state_q == S_PUSH);
	assign mem_wdata = {mem_rdata[PIX_W-1:0], px_q};

	bb_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (2 * PIX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (x_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// window control
	always_comb begin
		win_ctrl            = '0;
		win_ctrl.a_en       = top_q;
		win_ctrl.c_en       = (state_q == S_PUSH);
		win_ctrl.shift      = (state_q == S_PUSH) || (state_q == S_D0)
			|| (state_q == S_DSH) || (state_q == S_INV);
		win_ctrl.col_valid  = (state_q != S_INV);
		win_ctrl.hist_clear = (state_q == S_D0) || (state_q == S_PUSH && x_q == '0);
		win_ctrl.sum_load   = (state_q == S_SUM);
	end

	bb_window u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.row_a  (mem_rdata[2*PIX_W-1:PIX_W]),
		.row_b  (mem_rdata[PIX_W-1:0]),
		.row_c  (px_q),
		.numer  (numer),
		.recip  (recip)
	);

	assign rnd_load = (state_q == S_OUT) && rnd_free;

	bb_round u_rnd (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rnd_load),
		.numer   (numer),
		.recip   (recip),
		.last_in (last_q),
		.ready   (m_tready),
		.free    (rnd_free),
		.valid   (m_tvalid),
		.data    (m_tdata),
		.last    (m_tlast)
	);

	// sequencer, position counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			x_q       <= '0;
			px_q      <= '0;
			top_q     <= 1'b0;
			emit1_q   <= 1'b0;
			second_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (push_ok) begin
						x_q      <= in_col_q;
						px_q     <= s_tdata;
						top_q    <= in_row_q >= 16'd2;
						emit1_q  <= (in_row_q != '0) && (in_col_q != '0);
						second_q <= (in_row_q != '0) && (in_col_q == last_col);
						last_q   <= 1'b0;
						if (in_col_q == last_col) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + 16'd1;
						end else begin
							in_col_q <= in_col_q + CW'(1);
						end
						state_q <= S_PUSH;
					end else if (drain_ok) begin
						top_q    <= height_q >= 16'd2;
						second_q <= 1'b0;
						last_q   <= (out_col_q == last_col);
						if (out_col_q == last_col) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
						if (out_col_q == '0) begin
							state_q <= S_D0;
						end else if (out_col_q < last_col) begin
							state_q <= S_DSH;
						end else begin
							state_q <= S_INV;
						end
					end
				end
				S_PUSH: begin
					if (emit1_q) begin
						state_q <= S_SUM;
					end else if (second_q) begin
						second_q <= 1'b0;
						state_q  <= S_INV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_D0: begin
					state_q <= (last_col != '0) ? S_DSH : S_INV;
				end
				S_DSH: begin
					state_q <= S_SUM;
				end
				S_INV: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rnd_free) begin
						if (second_q) begin
							second_q <= 1'b0;
							state_q  <= S_INV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register write restarts the frame
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_wdata[WIDTH_W-1:0];
					REG_HEIGHT: height_q <= cfg_wdata[HEIGHT_W-1:0];
					default:    ;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	// every emitted average has a neighbor count from the table
	a_recip_known: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (recip != '0))
		else $error("window sum loaded with an impossible neighbor count");

	// line store never reads and writes back in the same cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line store read overlaps write back");

	// the row-end result is never left pending when a new beat is taken
	a_second_done: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !second_q)
		else $error("second result still pending while idle");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bb_line_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb_line_mem: line store RAM
// One write port, one read port, registered read data.
// Each word holds the older and the newer row entry of one column.
// ----------------------------------------------------------------------------
module bb_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 48
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bb_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb_window: 3-column sliding window
// Holds per-column channel sums with a valid bit per slot, and registers the
// window sum as 2*sum + n together with the reciprocal of 2n.
// ----------------------------------------------------------------------------
module bb_window
	import bb_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire win_ctrl_t                   ctrl,
	input  wire logic [PIX_W-1:0]            row_a,
	input  wire logic [PIX_W-1:0]            row_b,
	input  wire logic [PIX_W-1:0]            row_c,
	output logic      [CH_N-1:0][NUM_W-1:0]  numer,
	output logic      [RECIP_W-1:0]          recip
);

	logic [SLOTS-1:0][CH_N-1:0][COL_W-1:0] slot_q;
	logic [SLOTS-1:0]                      vld_q;
	logic [1:0]                            rows_q;
	logic [CH_N-1:0][COL_W-1:0]            col;
	logic [1:0]                            col_rows;
	logic [CH_N-1:0][SUM_W-1:0]            sum_c;
	logic [1:0]                            nvalid;
	logic [CNT_W-1:0]                      n_c;
	logic [CH_N-1:0][NUM_W-1:0]            numer_q;
	logic [RECIP_W-1:0]                    recip_q;

	// new column: masked rows added per channel
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			col[ch] = COL_W'(row_b[ch*CHAN_W +: CHAN_W]);
			if (ctrl.a_en) begin
				col[ch] = col[ch] + COL_W'(row_a[ch*CHAN_W +: CHAN_W]);
			end
			if (ctrl.c_en) begin
				col[ch] = col[ch] + COL_W'(row_c[ch*CHAN_W +: CHAN_W]);
			end
		end
		col_rows = 2'd1 + {1'b0, ctrl.a_en} + {1'b0, ctrl.c_en};
	end

	// window sum over valid slots
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			sum_c[ch] = '0;
			for (int k = 0; k < SLOTS; k++) begin
				if (vld_q[k]) begin
					sum_c[ch] = sum_c[ch] + SUM_W'(slot_q[k][ch]);
				end
			end
		end
		nvalid = 2'($countones(vld_q));
		n_c    = CNT_W'(nvalid) * CNT_W'(rows_q);
	end

	// slot data: shift toward slot 0
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
			slot_q[2] <= col;
		end
	end

	// slot valid bits and row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rows_q <= 2'd1;
		end else if (ctrl.shift) begin
			vld_q[2] <= ctrl.col_valid;
			vld_q[1] <= ctrl.hist_clear ? 1'b0 : vld_q[2];
			vld_q[0] <= ctrl.hist_clear ? 1'b0 : vld_q[1];
			if (ctrl.col_valid) begin
				rows_q <= col_rows;
			end
		end
	end

	// registered numerator and reciprocal
	always_ff @(posedge clk) begin
		if (ctrl.sum_load) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				numer_q[ch] <= NUM_W'({sum_c[ch], 1'b0}) + NUM_W'(n_c);
			end
			recip_q <= bb_recip(n_c);
		end
	end

	assign numer = numer_q;
	assign recip = recip_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bb_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb_round: rounded average and output register
// Multiplies each numerator by the reciprocal of 2n and holds the result beat
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module bb_round
	import bb_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [CH_N-1:0][NUM_W-1:0] numer,
	input  wire logic [RECIP_W-1:0]         recip,
	input  wire logic                       last_in,
	input  wire logic                       ready,
	output logic                            free,
	output logic                            valid,
	output logic      [PIX_W-1:0]           data,
	output logic                            last
);

	logic [CH_N-1:0][PROD_W-1:0] prod;
	logic [PIX_W-1:0]            data_q;
	logic                        last_q;
	logic                        valid_q;

	// quotient = (numer * recip) >> RECIP_SHIFT
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			prod[ch] = PROD_W'(numer[ch]) * PROD_W'(recip);
		end
	end

	assign free = !valid_q || ready;

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				data_q[ch*CHAN_W +: CHAN_W] <= prod[ch][RECIP_SHIFT +: CHAN_W];
			end
			last_q <= last_in;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign last  = last_q;

endmodule
`default_nettype wire

// ----- verif/box_blur_3x3_edge_aware_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_tb: self-checking bench for the 3x3 box blur
// Streams RGB frames of many shapes through the blur with random gaps on both
// sides. A behavioral copy of the blur predicts every output beat, and each
// output beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_tb
	import bb_pkg::*;
;

	localparam int MAX_W          = 2048;
	localparam int SETTLE_CYCLES  = 12;    // a drain or dropped beat finishes well within this
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat and no write
	localparam int RANDOM_ITEMS   = 380;

	// red in the low byte, as on the stream
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct {
		rgb_t pix;
		logic is_last;
	} blurred_t;

	typedef struct {
		int r;
		int g;
		int b;
		int n;
	} tally_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [PIX_W-1:0] s_tdata   = '0;
	logic             s_tuser   = CMD_PUSH;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [PIX_W-1:0] m_tdata;
	logic             m_tlast;

	// blur predictor state
	rgb_t            line_old [MAX_W];
	rgb_t            line_new [MAX_W];
	rgb_t            win_top  [3];   // index 0 is the oldest column
	rgb_t            win_mid  [3];
	rgb_t            win_bot  [3];
	logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RST;
	logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RST;
	int              in_col  = 0;
	int              in_row  = 0;
	int              out_col = 0;

	blurred_t        blurred_q [$];

	// bookkeeping
	bit calm = 1'b0;
	int fail_count     = 0;
	int pixels_taken   = 0;
	int drains_taken   = 0;
	int beats_dropped  = 0;
	int reg_writes     = 0;
	int pixels_checked = 0;
	int frames_done    = 0;
	int stall_cycles   = 0;

	box_blur_3x3_edge_aware #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // in_red, in_green, in_blue
		.s_tuser   (s_tuser),   // command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // out_red, out_green, out_blue
		.m_tlast   (m_tlast)    // frame_end
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int used_width();
		int w;
		w = int'(cfg_width);
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int used_height();
		return (cfg_height == '0) ? 1 : int'(cfg_height);
	endfunction

	function automatic tally_t tally_add(tally_t t, rgb_t p);
		t.r += int'(p.red);
		t.g += int'(p.green);
		t.b += int'(p.blue);
		t.n += 1;
		return t;
	endfunction

	// rounded half up: (2*sum + n) / (2*n)
	function automatic rgb_t tally_mean(tally_t t);
		rgb_t m;
		m.red   = CHAN_W'((2 * t.r + t.n) / (2 * t.n));
		m.green = CHAN_W'((2 * t.g + t.n) / (2 * t.n));
		m.blue  = CHAN_W'((2 * t.b + t.n) / (2 * t.n));
		return m;
	endfunction

	// average over window columns from_slot..2, top row only when in frame
	function automatic rgb_t window_mean(int from_slot, bit with_top);
		tally_t t;
		int     k;
		t = '{0, 0, 0, 0};
		for (k = from_slot; k < 3; k++) begin
			if (with_top) t = tally_add(t, win_top[k]);
			t = tally_add(t, win_mid[k]);
			t = tally_add(t, win_bot[k]);
		end
		return tally_mean(t);
	endfunction

	function automatic void clear_position();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
	endfunction

	// works out the output beats caused by one accepted input beat
	function automatic bit predict_blur(logic cmd, rgb_t px);
		int     w, h, x, r, lo, hi, k;
		tally_t t;
		w = used_width();
		h = used_height();
		if (cmd == CMD_PUSH) begin
			x = in_col;
			r = in_row;
			if (r >= h || x >= w) return 1'b0;
			for (k = 0; k < 2; k++) begin
				win_top[k] = win_top[k + 1];
				win_mid[k] = win_mid[k + 1];
				win_bot[k] = win_bot[k + 1];
			end
			win_top[2]  = line_old[x];
			win_mid[2]  = line_new[x];
			win_bot[2]  = px;
			line_old[x] = line_new[x];
			line_new[x] = px;
			if (r >= 1) begin
				// pixel up and left of the new one
				if (x >= 1) begin
					blurred_q.push_back('{window_mean(x >= 2 ? 0 : 1, r >= 2), 1'b0});
					out_col = (out_col + 1 >= w) ? 0 : out_col + 1;
				end
				// row end also releases the pixel right above
				if (x == w - 1) begin
					blurred_q.push_back('{window_mean(x >= 1 ? 1 : 2, r >= 2), 1'b0});
					out_col = (out_col + 1 >= w) ? 0 : out_col + 1;
				end
			end
			x++;
			if (x >= w) begin
				x = 0;
				r++;
			end
			in_col = x;
			in_row = r;
			return 1'b1;
		end
		// drain: only once the whole frame is in
		if (in_row < h || out_col >= w) return 1'b0;
		lo = (out_col >= 1) ? out_col - 1 : 0;
		hi = (out_col + 1 < w) ? out_col + 1 : out_col;
		t  = '{0, 0, 0, 0};
		for (k = lo; k <= hi; k++) begin
			if (h >= 2) t = tally_add(t, line_old[k]);
			t = tally_add(t, line_new[k]);
		end
		if (out_col == w - 1) begin
			blurred_q.push_back('{tally_mean(t), 1'b1});
			clear_position();
		end else begin
			blurred_q.push_back('{tally_mean(t), 1'b0});
			out_col++;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// output side: random backpressure and checking
	// ------------------------------------------------------------------
	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%t ERROR %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin
		rgb_t     got;
		blurred_t want;
		m_tready <= calm || ($urandom_range(99) >= 33);
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (blurred_q.size() == 0) begin
				note_failure($sformatf("output beat with none pending: rgb=%h/%h/%h last=%b",
					got.red, got.green, got.blue, m_tlast));
			end else begin
				want = blurred_q.pop_front();
				pixels_checked++;
				if (want.is_last) frames_done++;
				if (got.red !== want.pix.red || got.green !== want.pix.green ||
					got.blue !== want.pix.blue || m_tlast !== want.is_last) begin
					note_failure($sformatf("pixel %0d: want rgb=%h/%h/%h last=%b, got rgb=%h/%h/%h last=%b",
						pixels_checked, want.pix.red, want.pix.green, want.pix.blue, want.is_last,
						got.red, got.green, got.blue, m_tlast));
				end
			end
		end
	end

	// watchdog: no beat and no write for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("box_blur_3x3_edge_aware_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	function automatic rgb_t pick_pixel(bit harsh);
		rgb_t p;
		if (harsh) begin
			p.red   = {CHAN_W{1'($urandom_range(1))}};
			p.green = {CHAN_W{1'($urandom_range(1))}};
			p.blue  = {CHAN_W{1'($urandom_range(1))}};
		end else begin
			p.red   = CHAN_W'($urandom_range(255));
			p.green = CHAN_W'($urandom_range(255));
			p.blue  = CHAN_W'($urandom_range(255));
		end
		return p;
	endfunction

	// one input beat; returns at the edge that took it, valid still high
	task automatic send_beat(input logic cmd, input rgb_t px);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		if (predict_blur(cmd, px)) begin
			if (cmd == CMD_PUSH) pixels_taken++;
			else drains_taken++;
		end else begin
			beats_dropped++;
		end
	endtask

	// stop sending until every predicted pixel has come out
	task automatic await_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (blurred_q.size() != 0) @(posedge clk);
	endtask

	// block fully idle: results out and any dropped beat finished
	task automatic settle();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		if (idx == REG_WIDTH) cfg_width = val[WIDTH_W-1:0];
		else if (idx == REG_HEIGHT) cfg_height = val[HEIGHT_W-1:0];
		clear_position();
	endtask

	task automatic push_pixels(input int count, input bit harsh);
		int k;
		for (k = 0; k < count; k++) send_beat(CMD_PUSH, pick_pixel(harsh));
	endtask

	task automatic drain_row(input int count);
		int k;
		for (k = 0; k < count; k++) send_beat(CMD_DRAIN, pick_pixel(1'b0));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// 640x480 out of reset: part of row 0 gives nothing, early drain is dropped
	task automatic test_reset_geometry();
		push_pixels(8, 1'b0);
		drain_row(1);
	endtask

	// clamped sizes, corners, edges, single row and single column
	task automatic test_edge_cases();
		// zero width and height behave as one pixel
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		drain_row(1);
		push_pixels(2, 1'b1);    // second push lands after the frame is in
		drain_row(1);
		// upper data bits beyond the width field are ignored
		write_reg(REG_WIDTH, 16'hF003);
		write_reg(REG_HEIGHT, 16'd3);
		push_pixels(9, 1'b1);
		drain_row(3);
		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd4);
		push_pixels(4, 1'b1);
		drain_row(1);
		write_reg(REG_WIDTH, 16'd4);
		write_reg(REG_HEIGHT, 16'd1);
		push_pixels(4, 1'b1);
		drain_row(4);
	endtask

	// a register write mid-frame drops the frame and restarts at pixel 0
	task automatic test_abandon();
		write_reg(REG_WIDTH, 16'd4);
		write_reg(REG_HEIGHT, 16'hFFFF);
		push_pixels(10, 1'b0);
		write_reg(REG_HEIGHT, 16'd3);
		push_pixels(12, 1'b0);
		drain_row(4);
	endtask

	// width just above the limit clamps to the full line store: no row wrap early
	task automatic test_widest_row();
		write_reg(REG_WIDTH, 16'h0801);
		write_reg(REG_HEIGHT, 16'd2);
		push_pixels(5, 1'b0);
		drain_row(1);
	endtask

	// random frames, mostly complete, some with noise or cut short
	task automatic test_random_frames();
		int  base, frame_no, w, h, total, cut, pause_at, k;
		bit  fresh;
		logic [CFG_DATA_W-1:0] wval;
		base     = pixels_taken + drains_taken;
		frame_no = 0;
		fresh    = 1'b1;
		w        = 1;
		h        = 1;
		while (pixels_taken + drains_taken - base < RANDOM_ITEMS) begin
			calm = (frame_no >= 8 && frame_no < 16);
			if (fresh || $urandom_range(99) < 60) begin
				if ($urandom_range(9) == 0) begin
					w = $urandom_range(64, 9);
					h = $urandom_range(3, 1);
				end else begin
					w = $urandom_range(8, 1);
					h = $urandom_range(5, 1);
				end
				wval = CFG_DATA_W'(w);
				if ($urandom_range(3) == 0) wval[CFG_DATA_W-1:WIDTH_W] = 4'($urandom_range(15));
				write_reg(REG_WIDTH, wval);
				write_reg(REG_HEIGHT, CFG_DATA_W'(h));
			end
			total    = w * h;
			cut      = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 0) : total;
			pause_at = (frame_no == 3 || $urandom_range(9) == 0) ?
				$urandom_range(total - 1, 0) : -1;
			for (k = 0; k < cut; k++) begin
				if (k == pause_at) await_results();
				if ($urandom_range(19) == 0) send_beat(CMD_DRAIN, pick_pixel(1'b0));
				send_beat(CMD_PUSH, pick_pixel($urandom_range(3) == 0));
			end
			if (cut < total) begin
				fresh = 1'b1;    // frame left unfinished, next write drops it
			end else begin
				if ($urandom_range(7) == 0) send_beat(CMD_PUSH, pick_pixel(1'b0));
				drain_row(w);
				fresh = 1'b0;
			end
			frame_no++;
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_edge_cases();
		test_abandon();
		test_widest_row();
		test_random_frames();
		settle();
		if (blurred_q.size() != 0)
			note_failure($sformatf("%0d predicted pixels never came out", blurred_q.size()));
		$display("sent %0d pixels and %0d drains (%0d beats dropped), %0d register writes",
			pixels_taken, drains_taken, beats_dropped, reg_writes);
		$display("checked %0d blurred pixels in %0d finished frames, %0d failures",
			pixels_checked, frames_done, fail_count);
		if (fail_count == 0 && blurred_q.size() == 0) begin
			$display("box_blur_3x3_edge_aware_tb OK");
		end else begin
			$display("box_blur_3x3_edge_aware_tb NOT OK");
		end
		$finish;
	end

endmodule
